// ===== sv/can_idf_pkg.sv =====
// Shared constants and types for the CAN receive identifier/mask filter.
package can_idf_pkg;

    localparam int FILTER_ENTRIES = 32;
    localparam int IDX_W          = $clog2(FILTER_ENTRIES);
    localparam int CNT_W          = $clog2(FILTER_ENTRIES + 1);
    localparam int ID_W           = 11;
    localparam int WORD_W         = ID_W + 1;
    localparam int ENTRY_W        = 2 * WORD_W;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int CFG_W          = 6;

    localparam logic OP_CONFIG = 1'b0;
    localparam logic OP_MATCH  = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t ident;
        word_t mask;
    } entry_t;

endpackage

// ===== sv/can_rx_id_mask_filter_top.sv =====
// Top level of the CAN receive identifier/mask acceptance filter.
// A configure word writes one filter entry when its index lies below the entries in use and
// returns its status through the done state and the output register. A match word scans the
// entries in use in index order, one table read per cycle from a memory with a registered
// read port, and stops at the first hit; with no entries in use it goes straight to the done
// state and reports a miss. A stalled earlier result holds the new result in the done state
// until the output register is free.
// One word is worked on at a time; the next word is taken while the previous result
// still waits in the output register. There is no clearing pass after reset.
module can_rx_id_mask_filter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [can_idf_pkg::PADDR_W-1:0]   paddr,
    input  logic [can_idf_pkg::PDATA_W-1:0]   pwdata,
    output logic [can_idf_pkg::PDATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              op,
    input  logic [can_idf_pkg::IDX_W-1:0]     entry_index,
    input  logic [can_idf_pkg::ID_W-1:0]      frame_ident,
    input  logic [can_idf_pkg::ID_W-1:0]      ident_mask,
    input  logic                              remote_request,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              status,
    output logic                              hit,
    output logic [can_idf_pkg::IDX_W-1:0]     matched_index
);
    import can_idf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [CFG_W-1:0]          entries_reg;
    logic [FILTER_ENTRIES-1:0] valid_bits_reg, valid_bits_next;
    word_t                     frame_reg, frame_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          issue_cnt_reg, issue_cnt_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]          rd_idx_reg, rd_idx_next;
    logic                      res_status_reg, res_status_next;
    logic                      res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]          res_idx_reg, res_idx_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    logic                      status_reg, status_next;
    logic                      hit_reg, hit_next;
    logic [IDX_W-1:0]          index_reg, index_next;

    entry_t                    mem [FILTER_ENTRIES];
    entry_t                    mem_q_reg;
    entry_t                    wr_data;
    logic                      wr_en;

    logic                      cfg_wr;
    logic                      req_accept;
    logic                      out_free;
    logic [CNT_W-1:0]          active_cnt;
    logic                      index_ok;
    logic                      entry_match;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRIES_IN_USE);
    assign prdata  = (paddr[2] == REG_ENTRIES_IN_USE) ?
                     {{(PDATA_W-CFG_W){1'b0}}, entries_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_wr)
        begin
            entries_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    assign active_cnt = (CNT_W'(entries_reg) > CNT_W'(FILTER_ENTRIES)) ?
                        CNT_W'(FILTER_ENTRIES) : CNT_W'(entries_reg);
    assign index_ok   = {1'b0, entry_index} < active_cnt;

    assign wr_en           = req_accept && (op == OP_CONFIG) && index_ok;
    assign wr_data.ident   = {frame_ident, remote_request};
    assign wr_data.mask    = {ident_mask, 1'b1};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[entry_index] <= wr_data;
        end
        mem_q_reg <= mem[issue_cnt_reg[IDX_W-1:0]];
    end

    assign entry_match = valid_bits_reg[rd_idx_reg] &&
                         (((frame_reg ^ mem_q_reg.ident) & mem_q_reg.mask) == '0);

    always_comb
    begin
        state_next      = state_reg;
        valid_bits_next = valid_bits_reg;
        frame_next      = frame_reg;
        n_next          = n_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        res_idx_next    = res_idx_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        status_next     = status_reg;
        hit_next        = hit_reg;
        index_next      = index_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    res_hit_next = 1'b0;
                    res_idx_next = '0;
                    if (op == OP_CONFIG)
                    begin
                        res_status_next = index_ok ? STATUS_OK : STATUS_BAD_INDEX;
                        if (index_ok)
                        begin
                            valid_bits_next[entry_index] = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        res_status_next = STATUS_OK;
                        frame_next      = {frame_ident, remote_request};
                        n_next          = active_cnt;
                        issue_cnt_next  = '0;
                        state_next      = (active_cnt == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_cnt_reg < n_reg)
                begin
                    rd_valid_next  = 1'b1;
                    rd_idx_next    = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    if (entry_match)
                    begin
                        res_hit_next  = 1'b1;
                        res_idx_next  = rd_idx_reg;
                        rd_valid_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else if ({1'b0, rd_idx_reg} == (n_reg - CNT_W'(1)))
                    begin
                        rd_valid_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    hit_next       = res_hit_reg;
                    index_next     = res_idx_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_bits_reg <= '0;
            rd_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_bits_reg <= valid_bits_next;
            rd_valid_reg   <= rd_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg      <= frame_next;
        n_reg          <= n_next;
        issue_cnt_reg  <= issue_cnt_next;
        rd_idx_reg     <= rd_idx_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        res_idx_reg    <= res_idx_next;
        status_reg     <= status_next;
        hit_reg        <= hit_next;
        index_reg      <= index_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign hit           = hit_reg;
    assign matched_index = index_reg;

    // A word that hits never carries an error status.
    a_hit_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && hit |-> status == STATUS_OK)
        else $error("hit reported together with an error status");

    // A miss reports index zero.
    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> matched_index == '0)
        else $error("miss reported with a nonzero index");

    // A reported hit names an entry that has been configured.
    a_hit_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && hit |-> valid_bits_reg[matched_index])
        else $error("hit on an entry that was never configured");

    // The scan never reads past the entries in use.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> issue_cnt_reg <= n_reg && n_reg != '0)
        else $error("scan ran past the entries in use");

endmodule

// ===== bench/can_rx_id_mask_filter_top_tb.sv =====
// Self-checking testbench for the CAN identifier/mask filter, with directed and random words.
module can_rx_id_mask_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import can_idf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic               op;
        logic [IDX_W-1:0]   entry_index;
        logic [ID_W-1:0]    frame_ident;
        logic [ID_W-1:0]    ident_mask;
        logic               remote_request;
    } filter_word_t;

    typedef struct {
        logic               status;
        logic               hit;
        logic [IDX_W-1:0]   matched_index;
    } filter_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic               op = OP_CONFIG;
    logic [IDX_W-1:0]   entry_index = '0;
    logic [ID_W-1:0]    frame_ident = '0;
    logic [ID_W-1:0]    ident_mask = '0;
    logic               remote_request = 1'b0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic               status;
    logic               hit;
    logic [IDX_W-1:0]   matched_index;

    logic [CFG_W-1:0]   model_count;
    logic               model_valid [FILTER_ENTRIES];
    word_t              model_ident [FILTER_ENTRIES];
    word_t              model_mask [FILTER_ENTRIES];

    filter_result_t     expected_results [$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;

    can_rx_id_mask_filter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .op             (op),
        .entry_index    (entry_index),
        .frame_ident    (frame_ident),
        .ident_mask     (ident_mask),
        .remote_request (remote_request),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .hit            (hit),
        .matched_index  (matched_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned searched_entries();
        return (model_count > FILTER_ENTRIES) ? FILTER_ENTRIES : int'(model_count);
    endfunction

    // Applies one word to the filter table copy and returns the result it must produce.
    function automatic filter_result_t predict_filter_result(filter_word_t w);
        filter_result_t r;
        int unsigned    n;
        word_t          frame;
        n = searched_entries();
        r.status = STATUS_OK;
        r.hit = 1'b0;
        r.matched_index = '0;
        if (w.op == OP_CONFIG)
        begin
            if (w.entry_index >= n)
            begin
                r.status = STATUS_BAD_INDEX;
            end
            else
            begin
                model_ident[w.entry_index] = {w.frame_ident, w.remote_request};
                model_mask[w.entry_index] = {w.ident_mask, 1'b1};
                model_valid[w.entry_index] = 1'b1;
            end
        end
        else
        begin
            frame = {w.frame_ident, w.remote_request};
            for (int i = 0; i < n; i++)
            begin
                if (model_valid[i] && ((frame ^ model_ident[i]) & model_mask[i]) == '0)
                begin
                    r.hit = 1'b1;
                    r.matched_index = IDX_W'(i);
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_result();
        filter_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result word arrived with nothing expected");
        end
        else
        begin
            want = expected_results.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status %b, expected %b", status, want.status));
            if (hit !== want.hit)
                report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
            if (matched_index !== want.matched_index)
                report_mismatch($sformatf("matched_index %0d, expected %0d",
                                          matched_index, want.matched_index));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_result();
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_filter_word(filter_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        op <= w.op;
        entry_index <= w.entry_index;
        frame_ident <= w.frame_ident;
        ident_mask <= w.ident_mask;
        remote_request <= w.remote_request;
        do
            @(posedge clk);
        while (req_stall);
        expected_results.push_back(predict_filter_result(w));
    endtask

    task automatic send_fields(logic o, int idx, int ident, int mask, logic rtr);
        filter_word_t w;
        w.op = o;
        w.entry_index = IDX_W'(idx);
        w.frame_ident = ID_W'(ident);
        w.ident_mask = ID_W'(mask);
        w.remote_request = rtr;
        send_filter_word(w);
    endtask

    task automatic wait_filter_idle();
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_entry_count(int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_ENTRIES_IN_USE, 2'b00};
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model_count = CFG_W'(value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic filter_word_t random_filter_word();
        filter_word_t w;
        int unsigned  n;
        int unsigned  pick;
        int unsigned  src;
        int unsigned  j;
        w.op = $urandom_range(0, 1);
        w.entry_index = IDX_W'($urandom);
        w.frame_ident = ID_W'($urandom);
        w.ident_mask = ID_W'($urandom);
        w.remote_request = $urandom_range(0, 1);
        n = searched_entries();
        pick = $urandom_range(99);
        if (pick < 10)
            return w;
        if (w.op == OP_CONFIG)
        begin
            if (n != 0 && pick < 85)
                w.entry_index = IDX_W'($urandom_range(0, n - 1));
            case ($urandom_range(0, 4))
                0: w.ident_mask = '0;
                1: w.ident_mask = '1;
                default: ;
            endcase
        end
        else if (pick < 75 && n != 0)
        begin
            src = $urandom_range(0, n - 1);
            for (int k = 0; k < n; k++)
            begin
                j = (src + k) % n;
                if (model_valid[j])
                begin
                    w.frame_ident = model_ident[j][WORD_W-1:1]
                                    ^ (ID_W'($urandom) & ~model_mask[j][WORD_W-1:1]);
                    w.remote_request = model_ident[j][0];
                    break;
                end
            end
        end
        return w;
    endfunction

    task automatic test_reset_defaults();
        send_fields(OP_CONFIG, 0, 11'h7ff, 11'h7ff, 1'b1);
        send_fields(OP_MATCH, 31, 11'h000, 11'h000, 1'b0);
        send_fields(OP_CONFIG, 31, 11'h000, 11'h000, 1'b0);
        wait_filter_idle();
    endtask

    task automatic test_table_extremes();
        write_entry_count(FILTER_ENTRIES);
        send_fields(OP_CONFIG, 0, 11'h7ff, 11'h7ff, 1'b1);
        send_fields(OP_CONFIG, 31, 11'h000, 11'h000, 1'b0);
        send_fields(OP_CONFIG, 15, 11'h555, 11'h2aa, 1'b0);
        send_fields(OP_MATCH, 0, 11'h7ff, 11'h7ff, 1'b1);
        send_fields(OP_MATCH, 31, 11'h000, 11'h7ff, 1'b0);
        send_fields(OP_MATCH, 7, 11'h2aa, 11'h000, 1'b0);
        send_fields(OP_MATCH, 0, 11'h123, 11'h555, 1'b1);
        send_fields(OP_CONFIG, 0, 11'h123, 11'h000, 1'b1);
        send_fields(OP_MATCH, 0, 11'h7ff, 11'h000, 1'b1);
        wait_filter_idle();
        write_entry_count(63);
        send_fields(OP_CONFIG, 31, 11'h3c3, 11'h7ff, 1'b1);
        send_fields(OP_MATCH, 0, 11'h3c3, 11'h000, 1'b1);
        wait_filter_idle();
        write_entry_count(FILTER_ENTRIES + 1);
        send_fields(OP_CONFIG, 31, 11'h000, 11'h000, 1'b0);
        send_fields(OP_MATCH, 0, 11'h2aa, 11'h000, 1'b0);
        wait_filter_idle();
    endtask

    task automatic test_shrunk_count();
        write_entry_count(16);
        send_fields(OP_MATCH, 0, 11'h2aa, 11'h000, 1'b0);
        send_fields(OP_CONFIG, 16, 11'h111, 11'h7ff, 1'b0);
        send_fields(OP_CONFIG, 31, 11'h222, 11'h7ff, 1'b1);
        send_fields(OP_CONFIG, 15, 11'h0f0, 11'h7f0, 1'b1);
        send_fields(OP_MATCH, 0, 11'h0ff, 11'h000, 1'b1);
        wait_filter_idle();
        write_entry_count(FILTER_ENTRIES);
        send_fields(OP_MATCH, 0, 11'h2aa, 11'h000, 1'b0);
        wait_filter_idle();
    endtask

    task automatic test_random_traffic();
        int count_value;
        for (int chunk = 0; chunk < 12; chunk++)
        begin
            case (chunk / 3)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            case ($urandom_range(0, 6))
                0: count_value = FILTER_ENTRIES;
                1: count_value = 63;
                2: count_value = $urandom_range(FILTER_ENTRIES + 1, 62);
                3: count_value = $urandom_range(0, 63);
                4: count_value = $urandom_range(9, FILTER_ENTRIES - 1);
                default: count_value = $urandom_range(1, 8);
            endcase
            if (chunk % 3 == 0)
                count_value = FILTER_ENTRIES;
            write_entry_count(count_value);
            repeat (50) send_filter_word(random_filter_word());
            wait_filter_idle();
        end
    endtask

    initial
    begin
        model_count = '0;
        for (int i = 0; i < FILTER_ENTRIES; i++)
        begin
            model_valid[i] = 1'b0;
            model_ident[i] = '0;
            model_mask[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_table_extremes();
        test_shrunk_count();
        test_random_traffic();
        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("expected result words left over at the end");
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/can_idf_pkg.sv
sv/can_rx_id_mask_filter_top.sv
bench/can_rx_id_mask_filter_top_tb.sv
